FILE: rtl/accel_limited_setpoint_ramp_top_defines.svh
// ----------------------------------------------------------------------------
// Setpoint ramp assertion macros
// Shared assertion forms clocked on aclk and disabled during aresetn.
// ----------------------------------------------------------------------------
`ifndef ACCEL_LIMITED_SETPOINT_RAMP_TOP_DEFINES_SVH
`define ACCEL_LIMITED_SETPOINT_RAMP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ALSR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("setpoint ramp check failed");
`define ALSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("setpoint ramp check failed");
`else
`define ALSR_ASSERT_IMPLY(label, ante, cons)
`define ALSR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/alsr_pkg.sv
// ----------------------------------------------------------------------------
// Setpoint ramp package
// Widths, register indexes, reset values and saturation shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alsr_pkg;

    localparam int POS_W  = 32;
    localparam int STEP_W = 29;
    localparam int GAIN_W = 29;
    localparam int DIST_W = 31;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 2;

    // Square root unit: 64-bit radicand, 32-bit root, two radicand bits a cycle.
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQ_CNT_W = $clog2(ROOT_W);

    // Divider: product of two step-wide values over twice the gain.
    localparam int DVD_W = 2 * STEP_W;
    localparam int DVS_W = GAIN_W + 1;
    localparam int DV_CNT_W = $clog2(DVD_W);

    localparam int PROD_W = GAIN_W + DIST_W;

    localparam logic [IDX_W-1:0] REG_MAX_STEP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEP_GAIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BRAKE_DIST = 2'd2;

    localparam logic [STEP_W-1:0] MAX_STEP_RST   = 29'd89478;
    localparam logic [GAIN_W-1:0] STEP_GAIN_RST  = 29'd2982;
    localparam logic [DIST_W-1:0] BRAKE_DIST_RST = 31'd1342177;

    // Clamp a wide signed value to the signed position range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] x);
        logic [64-POS_W:0] top;
        top = x[63:POS_W-1];
        if (top == '0 || top == '1) begin
            return x[POS_W-1:0];
        end else if (x[63]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/alsr_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alsr_isqrt (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [alsr_pkg::RAD_W-1:0]     radicand,
    output logic                                busy,
    output logic                                done,
    output logic [alsr_pkg::ROOT_W-1:0]         root
);

    logic [alsr_pkg::RAD_W-1:0]    rad_reg;
    logic [alsr_pkg::ROOT_W+1:0]   rem_reg;
    logic [alsr_pkg::ROOT_W-1:0]   root_reg;
    logic [alsr_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [alsr_pkg::ROOT_W+3:0]   rem_sh;
    logic [alsr_pkg::ROOT_W+3:0]   trial;
    logic                          fits;

    assign rem_sh = {rem_reg, rad_reg[alsr_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[alsr_pkg::RAD_W-3:0], 2'b00};
                if (fits) begin
                    rem_reg  <= (alsr_pkg::ROOT_W+2)'(rem_sh - trial);
                    root_reg <= {root_reg[alsr_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[alsr_pkg::ROOT_W+1:0];
                    root_reg <= {root_reg[alsr_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == alsr_pkg::SQ_CNT_W'(alsr_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: rtl/alsr_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alsr_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [alsr_pkg::DVD_W-1:0]   dividend,
    input  wire logic [alsr_pkg::DVS_W-1:0]   divisor,
    output logic                              busy,
    output logic                              done,
    output logic [alsr_pkg::DVD_W-1:0]        quotient
);

    logic [alsr_pkg::DVD_W-1:0]    quo_reg;
    logic [alsr_pkg::DVS_W-1:0]    dvs_reg;
    logic [alsr_pkg::DVS_W-1:0]    rem_reg;
    logic [alsr_pkg::DV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [alsr_pkg::DVS_W:0]      rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg, quo_reg[alsr_pkg::DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // Dividend bits leave at the top as quotient bits enter at the bottom.
                if (fits) begin
                    rem_reg <= alsr_pkg::DVS_W'(rem_sh - {1'b0, dvs_reg});
                end else begin
                    rem_reg <= rem_sh[alsr_pkg::DVS_W-1:0];
                end
                quo_reg <= {quo_reg[alsr_pkg::DVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == alsr_pkg::DV_CNT_W'(alsr_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/accel_limited_setpoint_ramp_top.sv
// Sequence: a restart request goes from S_CHK straight to S_MOVE; a normal request
// may run the serial divider (only when the switch point is moved) and none, one or
// two square root passes before S_MOVE.
// Throughput: one request at a time; the next is taken once the result register is
// loaded, even while that result still waits on m_tready.
// Reset: synchronous active-low aresetn clears the state, positions and output valid, and loads register defaults.
// ----------------------------------------------------------------------------
// Acceleration-limited setpoint ramp
// Sequencer around a shared multiplier, square root unit and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accel_limited_setpoint_ramp_top_defines.svh"

module accel_limited_setpoint_ramp_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,  // target_position, measured_position
    input  wire logic                          s_tuser,  // restart
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // setpoint
    output logic [1:0]                         m_tuser,  // reversed, braking
    input  wire logic                          cfg_wr_en,
    input  wire logic [alsr_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [alsr_pkg::CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_QMUL, S_QDIV, S_QWAIT, S_DIST,
        S_RAA, S_RAD, S_RSQ, S_RSW, S_STEP, S_MOVE
    } state_t;

    state_t state_reg;

    logic signed [31:0] t_reg, m_reg, s_reg, p_reg, w_reg;
    logic rst_reg, rev_reg, acc_reg, brk_reg, wb_reg, sel_reg;
    logic [alsr_pkg::STEP_W-1:0] ms_reg, last_reg, step_reg;
    logic [alsr_pkg::GAIN_W-1:0] ga_reg;
    logic [alsr_pkg::DIST_W-1:0] bd_reg, dist_reg;
    logic [31:0] sa_reg, sd_reg;
    logic [alsr_pkg::PROD_W-1:0] prod_reg;
    logic [alsr_pkg::DVD_W-1:0] aa_reg;
    logic [31:0] out_sp_reg;
    logic out_rev_reg, out_brk_reg, m_tvalid_reg;

    logic [alsr_pkg::GAIN_W-1:0] a_eff;
    logic [32:0] tm, pm, sw, ts, diff;
    logic [32:0] da, dd, diff_mag;
    logic rev_c;
    logic [alsr_pkg::STEP_W-1:0] dm;
    logic [alsr_pkg::GAIN_W-1:0] mul_x;
    logic [alsr_pkg::DIST_W-1:0] mul_y;
    logic [alsr_pkg::PROD_W-1:0] prod_c;
    logic [alsr_pkg::RAD_W-1:0] rad;
    logic [32:0] st_sum;
    logic [31:0] pick;
    logic [alsr_pkg::STEP_W-1:0] step_next;
    logic signed [63:0] qs, w_wide, mv_wide;
    logic signed [31:0] base, sp_next;

    logic sq_start, sq_busy, sq_done;
    logic [alsr_pkg::ROOT_W-1:0] sq_root;
    logic dv_start, dv_busy, dv_done;
    logic [alsr_pkg::DVD_W-1:0] dv_quo;
    logic out_free;

    assign a_eff = (ga_reg == '0) ? alsr_pkg::GAIN_W'(1) : ga_reg;

    assign tm    = {t_reg[31], t_reg} - {m_reg[31], m_reg};
    assign pm    = {p_reg[31], p_reg} - {m_reg[31], m_reg};
    assign rev_c = tm[32] ^ pm[32];
    assign dm    = (last_reg >= a_eff) ? last_reg - a_eff : a_eff - last_reg;

    assign sw = {s_reg[31], s_reg} - {w_reg[31], w_reg};
    assign ts = {t_reg[31], t_reg} - {s_reg[31], s_reg};
    assign da = sw[32] ? 33'(-sw) : sw;
    assign dd = ts[32] ? 33'(-ts) : ts;

    always_comb begin
        unique case (state_reg)
            S_QMUL: begin
                mul_x = last_reg;
                mul_y = {2'b00, dm};
            end
            S_RAA: begin
                mul_x = a_eff;
                mul_y = {2'b00, a_eff};
            end
            default: begin
                mul_x = a_eff;
                mul_y = dist_reg;
            end
        endcase
    end

    assign prod_c = alsr_pkg::PROD_W'(mul_x) * alsr_pkg::PROD_W'(mul_y);

    // a*a + 8*a*d, the radicand of the ramp step.
    assign rad    = {6'b0, aa_reg} + {1'b0, prod_reg, 3'b000};
    assign st_sum = {4'b0, a_eff} + {1'b0, sq_root};

    // Switch point moved back by the distance covered while braking.
    assign qs     = (last_reg < a_eff) ? -64'(signed'({6'b0, dv_quo}))
                                       : 64'(signed'({6'b0, dv_quo}));
    assign w_wide = (s_reg > w_reg) ? 64'(s_reg) - qs : 64'(s_reg) + qs;

    always_comb begin
        if (acc_reg && brk_reg) begin
            pick = (sa_reg < sd_reg) ? sa_reg : sd_reg;
        end else if (brk_reg) begin
            pick = sd_reg;
        end else if (acc_reg) begin
            pick = sa_reg;
        end else begin
            pick = {3'b000, ms_reg};
        end
        step_next = (pick > {3'b000, ms_reg}) ? ms_reg : pick[alsr_pkg::STEP_W-1:0];
    end

    assign base     = rev_reg ? m_reg : s_reg;
    assign diff     = {t_reg[31], t_reg} - {base[31], base};
    assign diff_mag = diff[32] ? 33'(-diff) : diff;
    assign mv_wide  = diff[32] ? 64'(base) - 64'(step_reg) : 64'(base) + 64'(step_reg);
    assign sp_next  = (diff_mag > {4'b0, step_reg}) ? alsr_pkg::sat_pos(mv_wide) : t_reg;

    assign sq_start = (state_reg == S_RSQ);
    assign dv_start = (state_reg == S_QDIV);
    assign out_free = !m_tvalid_reg || m_tready;

    alsr_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (rad),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    alsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (prod_reg[alsr_pkg::DVD_W-1:0]),
        .divisor  ({a_eff, 1'b0}),
        .busy     (dv_busy),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ms_reg       <= alsr_pkg::MAX_STEP_RST;
            ga_reg       <= alsr_pkg::STEP_GAIN_RST;
            bd_reg       <= alsr_pkg::BRAKE_DIST_RST;
            s_reg        <= '0;
            p_reg        <= '0;
            w_reg        <= '0;
            last_reg     <= '0;
            wb_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            prod_reg <= prod_c;
            // In S_MOVE a taken result is replaced by the new one below.
            if (m_tvalid_reg && m_tready && state_reg != S_MOVE) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    alsr_pkg::REG_MAX_STEP:   ms_reg <= cfg_wdata[alsr_pkg::STEP_W-1:0];
                    alsr_pkg::REG_STEP_GAIN:  ga_reg <= cfg_wdata[alsr_pkg::GAIN_W-1:0];
                    alsr_pkg::REG_BRAKE_DIST: bd_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        t_reg     <= s_tdata[31:0];
                        m_reg     <= s_tdata[63:32];
                        rst_reg   <= s_tuser;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    rev_reg <= rev_c;
                    acc_reg <= 1'b0;
                    brk_reg <= 1'b0;
                    if (rst_reg) begin
                        state_reg <= S_MOVE;
                    end else if (rev_c) begin
                        w_reg     <= s_reg;
                        state_reg <= S_DIST;
                    end else if (t_reg != p_reg && wb_reg) begin
                        state_reg <= S_QMUL;
                    end else begin
                        state_reg <= S_DIST;
                    end
                end
                S_QMUL: state_reg <= S_QDIV;
                S_QDIV: state_reg <= S_QWAIT;
                S_QWAIT: begin
                    if (dv_done) begin
                        w_reg     <= alsr_pkg::sat_pos(w_wide);
                        state_reg <= S_DIST;
                    end
                end
                S_DIST: begin
                    acc_reg <= da < {2'b00, bd_reg};
                    brk_reg <= dd < {2'b00, bd_reg};
                    if (da < {2'b00, bd_reg}) begin
                        sel_reg   <= 1'b0;
                        dist_reg  <= da[alsr_pkg::DIST_W-1:0];
                        state_reg <= S_RAA;
                    end else if (dd < {2'b00, bd_reg}) begin
                        sel_reg   <= 1'b1;
                        dist_reg  <= dd[alsr_pkg::DIST_W-1:0];
                        state_reg <= S_RAA;
                    end else begin
                        state_reg <= S_STEP;
                    end
                end
                S_RAA: state_reg <= S_RAD;
                S_RAD: begin
                    aa_reg    <= prod_reg[alsr_pkg::DVD_W-1:0];
                    state_reg <= S_RSQ;
                end
                S_RSQ: state_reg <= S_RSW;
                S_RSW: begin
                    if (sq_done) begin
                        if (!sel_reg) begin
                            sa_reg <= st_sum[32:1];
                            if (brk_reg) begin
                                sel_reg   <= 1'b1;
                                dist_reg  <= dd[alsr_pkg::DIST_W-1:0];
                                state_reg <= S_RAA;
                            end else begin
                                state_reg <= S_STEP;
                            end
                        end else begin
                            sd_reg    <= st_sum[32:1];
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    step_reg  <= step_next;
                    state_reg <= S_MOVE;
                end
                S_MOVE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                        if (rst_reg) begin
                            s_reg       <= m_reg;
                            p_reg       <= m_reg;
                            w_reg       <= m_reg;
                            last_reg    <= '0;
                            wb_reg      <= 1'b0;
                            out_sp_reg  <= m_reg;
                            out_rev_reg <= 1'b0;
                            out_brk_reg <= 1'b0;
                        end else begin
                            s_reg       <= sp_next;
                            p_reg       <= t_reg;
                            last_reg    <= step_reg;
                            wb_reg      <= brk_reg;
                            out_sp_reg  <= sp_next;
                            out_rev_reg <= rev_reg;
                            out_brk_reg <= brk_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_sp_reg;
    assign m_tuser  = {out_brk_reg, out_rev_reg};

    `ALSR_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    `ALSR_ASSERT_IMPLY(a_result_from_move, $rose(m_tvalid_reg), $past(state_reg) == S_MOVE)
    `ALSR_ASSERT_IMPLY(a_step_capped, state_reg == S_MOVE && !rst_reg, step_reg <= ms_reg)
    `ALSR_ASSERT_IMPLY(a_units_exclusive, 1'b1, !(sq_busy && dv_busy))

endmodule

`default_nettype wire
